### src/spq_pkg.sv
// spq_pkg: shared types and codes for the sorted minimum priority queue
// holds the operation and status codes and the command bundle sent down the cell row
// no dependencies

package spq_pkg;

	localparam int KEY_W = 32;
	localparam int STATUS_W = 3;
	localparam int OCC_W = 8;

	typedef enum logic [1:0] {
		OP_EXTRACT  = 2'd0,
		OP_INSERT   = 2'd1,
		OP_DECREASE = 2'd2,
		OP_NOP      = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_LARGER   = 3'd4
	} status_t;

	// broadcast to every cell: sample flags on the accept edge, apply on the commit edge
	typedef struct packed {
		logic              sample;
		logic              commit;
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [KEY_W-1:0]  new_key;
	} cell_cmd_t;

endpackage

### src/spq_cell.sv
// spq_cell: one slot of the sorted row, holds a key and a live flag
// compares against the broadcast keys and shifts with its neighbors
// depends on spq_pkg

module spq_cell #(
	parameter bit FIRST = 1'b0,
	parameter bit LAST  = 1'b0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spq_pkg::cell_cmd_t           cmd,
	input  logic [spq_pkg::KEY_W-1:0]    left_key,
	input  logic                         left_gt,
	input  logic                         left_lt,
	input  logic                         left_live,
	input  logic [spq_pkg::KEY_W-1:0]    right_key,
	input  logic                         right_live,
	output logic [spq_pkg::KEY_W-1:0]    cell_key,
	output logic                         gt,
	output logic                         lt,
	output logic                         live,
	output logic                         hit
);

	logic [spq_pkg::KEY_W-1:0] key_q;
	logic [spq_pkg::KEY_W-1:0] operand;
	logic                      live_q;
	logic                      gt_q;
	logic                      lt_q;
	logic                      eq_q;
	logic                      in_span;
	logic                      take_bcast;

	// for the greater-than flag, insert compares against key, decrease against new_key
	assign operand = (cmd.op == spq_pkg::OP_INSERT) ? cmd.key : cmd.new_key;

	// first match: left neighbor holds a strictly smaller key
	assign hit        = eq_q && (FIRST || left_lt);
	assign in_span    = lt_q || hit;
	assign take_bcast = FIRST || !left_gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			gt_q   <= 1'b0;
			lt_q   <= 1'b0;
			eq_q   <= 1'b0;
		end else begin
			if (cmd.sample) begin
				gt_q <= !live_q || ($signed(key_q) > $signed(operand));
				lt_q <= live_q && ($signed(key_q) < $signed(cmd.key));
				eq_q <= live_q && (key_q == cmd.key);
			end
			if (cmd.commit) begin
				unique case (cmd.op)
					spq_pkg::OP_EXTRACT: begin
						live_q <= LAST ? 1'b0 : right_live;
					end
					spq_pkg::OP_INSERT: begin
						live_q <= live_q || FIRST || left_live;
					end
					spq_pkg::OP_DECREASE,
					spq_pkg::OP_NOP: begin
						live_q <= live_q;
					end
					default: begin
						live_q <= live_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			unique case (cmd.op)
				spq_pkg::OP_EXTRACT: begin
					if (!LAST)
						key_q <= right_key;
				end
				spq_pkg::OP_INSERT: begin
					if (gt_q)
						key_q <= take_bcast ? cmd.key : left_key;
				end
				spq_pkg::OP_DECREASE: begin
					if (in_span && gt_q)
						key_q <= take_bcast ? cmd.new_key : left_key;
				end
				spq_pkg::OP_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign cell_key = key_q;
	assign gt       = gt_q;
	assign lt       = lt_q;
	assign live     = live_q;

endmodule

### src/sorted_min_priority_queue.sv
// sorted_min_priority_queue: top level, controller plus a row of CAPACITY cells
// keeps signed keys in ascending order, cell 0 holds the minimum
// depends on spq_pkg and spq_cell
//
//  channel   | handshake          | fields
//  ----------+--------------------+--------------------------------
//  command   | start, busy        | op, key, new_key
//  result    | done (one cycle)   | status, min_value, occupancy
//
// for each item, on the accept edge every cell compares its key
// against the broadcast keys and registers the flags, on the next edge the
// found/full/empty decision is made and every cell shifts or loads at once
// busy is high between the accept and commit edges, so no new item is taken meanwhile
// done pulses in the cycle after the commit edge, that cycle may already accept
// the receiver cannot stall; results are never held back
// reset clears the count and all live flags; keys themselves are not cleared

module sorted_min_priority_queue #(
	parameter int CAPACITY = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         op,
	input  logic signed [spq_pkg::KEY_W-1:0]   key,
	input  logic signed [spq_pkg::KEY_W-1:0]   new_key,
	output logic                               done,
	output logic [spq_pkg::STATUS_W-1:0]       status,
	output logic signed [spq_pkg::KEY_W-1:0]   min_value,
	output logic [spq_pkg::OCC_W-1:0]          occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                          busy_q;
	logic                          done_q;
	spq_pkg::op_t                  op_q;
	logic [spq_pkg::KEY_W-1:0]     key_q;
	logic [spq_pkg::KEY_W-1:0]     new_key_q;
	logic [CW-1:0]                 count_q;
	spq_pkg::status_t              status_q;
	logic [spq_pkg::KEY_W-1:0]     min_q;

	spq_pkg::cell_cmd_t            cmd;
	spq_pkg::status_t              status_d;
	logic                          accept;
	logic                          found;
	logic                          empty;
	logic                          full;
	logic                          larger;
	logic                          success;

	logic [spq_pkg::KEY_W-1:0]     key_w [CAPACITY];
	logic [CAPACITY-1:0]           gt_w;
	logic [CAPACITY-1:0]           lt_w;
	logic [CAPACITY-1:0]           live_w;
	logic [CAPACITY-1:0]           hit_w;

	assign accept = start && !busy_q;

	// condition checks on the stored item during the commit cycle
	assign found  = |hit_w;
	assign empty  = (count_q == '0);
	assign full   = (count_q >= CW'(CAPACITY));
	assign larger = $signed(new_key_q) > $signed(key_q);

	always_comb begin
		status_d = spq_pkg::ST_OK;
		success  = 1'b0;
		unique case (op_q)
			spq_pkg::OP_EXTRACT: begin
				status_d = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
				success  = !empty;
			end
			spq_pkg::OP_INSERT: begin
				status_d = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
				success  = !full;
			end
			spq_pkg::OP_DECREASE: begin
				// the size check comes before the search
				priority if (larger) begin
					status_d = spq_pkg::ST_LARGER;
				end else if (!found) begin
					status_d = spq_pkg::ST_NOTFOUND;
				end else begin
					status_d = spq_pkg::ST_OK;
					success  = 1'b1;
				end
			end
			spq_pkg::OP_NOP: begin
				status_d = spq_pkg::ST_OK;
			end
			default: begin
				status_d = spq_pkg::ST_OK;
			end
		endcase
	end

	// the cells see the live ports while sampling and the stored item while committing
	always_comb begin
		cmd.sample  = accept;
		cmd.commit  = busy_q && success;
		cmd.op      = busy_q ? op_q : spq_pkg::op_t'(op);
		cmd.key     = busy_q ? key_q : key;
		cmd.new_key = busy_q ? new_key_q : new_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
			status_q <= spq_pkg::ST_OK;
		end else begin
			done_q <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q   <= 1'b0;
				status_q <= status_d;
				if (success && (op_q == spq_pkg::OP_EXTRACT))
					count_q <= count_q - CW'(1);
				else if (success && (op_q == spq_pkg::OP_INSERT))
					count_q <= count_q + CW'(1);
			end
		end
	end

	// stored item and extracted value, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= spq_pkg::op_t'(op);
			key_q     <= key;
			new_key_q <= new_key;
		end
		if (busy_q)
			min_q <= (success && (op_q == spq_pkg::OP_EXTRACT)) ? key_w[0] : '0;
	end

	// row of cells, each wired to its two neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [spq_pkg::KEY_W-1:0] lk;
		logic [spq_pkg::KEY_W-1:0] rk;
		logic                      lg;
		logic                      ll;
		logic                      lv;
		logic                      rv;

		if (i == 0) begin : g_left_edge
			assign lk = key_w[i];
			assign lg = 1'b0;
			assign ll = 1'b0;
			assign lv = 1'b0;
		end else begin : g_left
			assign lk = key_w[i-1];
			assign lg = gt_w[i-1];
			assign ll = lt_w[i-1];
			assign lv = live_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_right_edge
			assign rk = key_w[i];
			assign rv = 1'b0;
		end else begin : g_right
			assign rk = key_w[i+1];
			assign rv = live_w[i+1];
		end

		spq_cell #(
			.FIRST (i == 0),
			.LAST  (i == CAPACITY - 1)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_key   (lk),
			.left_gt    (lg),
			.left_lt    (ll),
			.left_live  (lv),
			.right_key  (rk),
			.right_live (rv),
			.cell_key   (key_w[i]),
			.gt         (gt_w[i]),
			.lt         (lt_w[i]),
			.live       (live_w[i]),
			.hit        (hit_w[i])
		);
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign status    = status_q;
	assign min_value = min_q;
	assign occupancy = spq_pkg::OCC_W'(count_q);

	// the live flags in the row always agree with the count
	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(live_w) == int'(count_q))
		else $error("live flags disagree with count");

	// count never exceeds the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count above capacity");

	// a result only follows a cycle with busy high
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work cycle");

	// a high busy is always followed by a low busy
	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held too long");

	// the live flags form a run from cell 0
	a_live_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((live_w + CAPACITY'(1)) & live_w) == '0)
		else $error("live flags not contiguous");

endmodule
